@@ rtl/core/chpe_pkg.sv @@
package chpe_pkg;

	localparam int WORD_W = 32;
	localparam int CFG_W  = 64;
	localparam int IDX_W  = 4;
	localparam int DEG_W  = 3;

	localparam logic [IDX_W-1:0] REG_DEGREE = 4'd0;
	localparam logic [IDX_W-1:0] REG_COEF0  = 4'd1;

	typedef logic signed [WORD_W-1:0] word_t;

	// one beat travelling down the Horner chain
	typedef struct packed {
		logic  valid;
		logic  ovf;
		word_t acc_re;
		word_t acc_im;
		word_t z_re;
		word_t z_im;
	} chpe_beat_t;

endpackage

@@ rtl/core/chpe_cell.sv @@
module chpe_cell
	import chpe_pkg::*;
#(
	parameter int FRAC_BITS = 27
) (
	input  logic       clk,
	input  logic       arst_n,
	input  chpe_beat_t beat_in,
	input  word_t      coef_re,
	input  word_t      coef_im,
	input  logic       load,
	output chpe_beat_t beat_out
);

	localparam int PROD_W = 2 * WORD_W;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32'h7FFF_FFFF);
	localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32'h8000_0000);

	// stage 1: the four partial products of acc * z
	logic                     valid_s1;
	logic                     ovf_s1;
	word_t                    z_re_s1;
	word_t                    z_im_s1;
	logic signed [PROD_W-1:0] prod_rr_s1;
	logic signed [PROD_W-1:0] prod_ii_s1;
	logic signed [PROD_W-1:0] prod_ri_s1;
	logic signed [PROD_W-1:0] prod_ir_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s1     <= beat_in.ovf;
		z_re_s1    <= beat_in.z_re;
		z_im_s1    <= beat_in.z_im;
		prod_rr_s1 <= beat_in.acc_re * beat_in.z_re;
		prod_ii_s1 <= beat_in.acc_im * beat_in.z_im;
		prod_ri_s1 <= beat_in.acc_re * beat_in.z_im;
		prod_ir_s1 <= beat_in.acc_im * beat_in.z_re;
	end

	// stage 2: round, add coefficient, saturate
	logic signed [SUM_W-1:0] sum_re;
	logic signed [SUM_W-1:0] sum_im;
	logic signed [SUM_W-1:0] tot_re;
	logic signed [SUM_W-1:0] tot_im;
	word_t                   res_re;
	word_t                   res_im;
	logic                    sat_re;
	logic                    sat_im;

	always_comb begin
		sum_re = SUM_W'(prod_rr_s1) - SUM_W'(prod_ii_s1) + HALF;
		sum_im = SUM_W'(prod_ri_s1) + SUM_W'(prod_ir_s1) + HALF;
		tot_re = (sum_re >>> FRAC_BITS) + SUM_W'(coef_re);
		tot_im = (sum_im >>> FRAC_BITS) + SUM_W'(coef_im);
		sat_re = 1'b1;
		sat_im = 1'b1;
		if (tot_re > SAT_MAX) begin
			res_re = word_t'(SAT_MAX[WORD_W-1:0]);
		end else if (tot_re < SAT_MIN) begin
			res_re = word_t'(SAT_MIN[WORD_W-1:0]);
		end else begin
			res_re = tot_re[WORD_W-1:0];
			sat_re = 1'b0;
		end
		if (tot_im > SAT_MAX) begin
			res_im = word_t'(SAT_MAX[WORD_W-1:0]);
		end else if (tot_im < SAT_MIN) begin
			res_im = word_t'(SAT_MIN[WORD_W-1:0]);
		end else begin
			res_im = tot_im[WORD_W-1:0];
			sat_im = 1'b0;
		end
	end

	logic  valid_s2;
	logic  ovf_s2;
	word_t acc_re_s2;
	word_t acc_im_s2;
	word_t z_re_s2;
	word_t z_im_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// at or above the degree in use the stage just loads its coefficient
	always_ff @(posedge clk) begin
		z_re_s2 <= z_re_s1;
		z_im_s2 <= z_im_s1;
		if (load) begin
			acc_re_s2 <= coef_re;
			acc_im_s2 <= coef_im;
			ovf_s2    <= ovf_s1;
		end else begin
			acc_re_s2 <= res_re;
			acc_im_s2 <= res_im;
			ovf_s2    <= ovf_s1 | sat_re | sat_im;
		end
	end

	assign beat_out = '{
		valid:  valid_s2,
		ovf:    ovf_s2,
		acc_re: acc_re_s2,
		acc_im: acc_im_s2,
		z_re:   z_re_s2,
		z_im:   z_im_s2
	};

endmodule

@@ rtl/core/complex_horner_poly_eval.sv @@
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------
// input    | start, busy          | z_re, z_im
// result   | done (1-cycle pulse) | value_re, value_im, overflow
// config   | wr_en, wr_index      | wr_data
//
// One point is taken every cycle; busy never rises.
// Each Horner cell is a multiply stage followed by a round/add/saturate stage,
// and all MAX_DEGREE cells are present.
// Reset clears the degree, the coefficients and all in-flight beats.
// Results are presented once and cannot be held off.
module complex_horner_poly_eval
	import chpe_pkg::*;
#(
	parameter int MAX_DEGREE = 6,
	parameter int FRAC_BITS  = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  word_t            z_re,
	input  word_t            z_im,
	output logic             done,
	output word_t            value_re,
	output word_t            value_im,
	output logic             overflow,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0] wr_data
);

	logic [DEG_W-1:0] degree_q;
	logic [CFG_W-1:0] coef_q [0:MAX_DEGREE];
	logic [DEG_W-1:0] deg_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int i = 0; i <= MAX_DEGREE; i++) begin
				coef_q[i] <= '0;
			end
		end else if (wr_en) begin
			if (wr_index == REG_DEGREE) begin
				degree_q <= wr_data[DEG_W-1:0];
			end
			for (int i = 0; i <= MAX_DEGREE; i++) begin
				if (wr_index == REG_COEF0 + IDX_W'(i)) begin
					coef_q[i] <= wr_data;
				end
			end
		end
	end

	assign deg_eff = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;

	chpe_beat_t chain [0:MAX_DEGREE];

	assign busy     = 1'b0;
	assign chain[0] = '{
		valid:  start,
		ovf:    1'b0,
		acc_re: coef_q[MAX_DEGREE][CFG_W-1:WORD_W],
		acc_im: coef_q[MAX_DEGREE][WORD_W-1:0],
		z_re:   z_re,
		z_im:   z_im
	};

	for (genvar j = 0; j < MAX_DEGREE; j++) begin : g_cell
		localparam int K = MAX_DEGREE - 1 - j;
		chpe_cell #(
			.FRAC_BITS(FRAC_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.beat_in (chain[j]),
			.coef_re (coef_q[K][CFG_W-1:WORD_W]),
			.coef_im (coef_q[K][WORD_W-1:0]),
			.load    (DEG_W'(K) >= deg_eff),
			.beat_out(chain[j+1])
		);
	end

	assign done     = chain[MAX_DEGREE].valid;
	assign value_re = chain[MAX_DEGREE].acc_re;
	assign value_im = chain[MAX_DEGREE].acc_im;
	assign overflow = chain[MAX_DEGREE].ovf;

endmodule

@@ rtl/core/chpe_checker.sv @@
module chpe_checker
	import chpe_pkg::*;
#(
	parameter int MAX_DEGREE = 6
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input word_t            z_re,
	input word_t            z_im,
	input logic             done,
	input word_t            value_re,
	input word_t            value_im,
	input logic             overflow,
	input logic             wr_en,
	input logic [IDX_W-1:0] wr_index,
	input logic [CFG_W-1:0] wr_data
);

	localparam int LAT = 2 * MAX_DEGREE;

	logic [DEG_W-1:0] deg_q;
	logic [CFG_W-1:0] coef0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q   <= '0;
			coef0_q <= '0;
		end else if (wr_en) begin
			if (wr_index == REG_DEGREE) begin
				deg_q <= wr_data[DEG_W-1:0];
			end
			if (wr_index == REG_COEF0) begin
				coef0_q <= wr_data;
			end
		end
	end

	a_beat_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat gave no result");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted beat");

	a_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && z_re == '0 && z_im == '0) |-> ##LAT
		(!overflow && value_re == word_t'(coef0_q[CFG_W-1:WORD_W])
			&& value_im == word_t'(coef0_q[WORD_W-1:0])))
		else $error("p(0) differs from constant coefficient");

	a_deg0_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && deg_q == '0) |-> (!overflow
			&& value_re == word_t'(coef0_q[CFG_W-1:WORD_W])
			&& value_im == word_t'(coef0_q[WORD_W-1:0])))
		else $error("degree zero result is not the constant coefficient");

endmodule

bind complex_horner_poly_eval chpe_checker #(.MAX_DEGREE(MAX_DEGREE)) u_chpe_checker (.*);
